FILE: design/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master register access package
// Shared types and codes for the tick-driven I2C register access master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned ByteW = 8;

  // request codes
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // completion codes
  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_START     = 2'd1;
  localparam logic [1:0] ERR_ADDR_NACK = 2'd2;
  localparam logic [1:0] ERR_ZERO_CNT  = 2'd3;

  localparam logic [ByteW-1:0] BIT_MSB = 8'h80;
  localparam logic [ByteW-1:0] BIT_LSB = 8'h01;

  // bus sequencer steps: start, transmit, write ack, stop, receive, master ack
  typedef enum logic [20:0] {
    ST_IDLE = 21'h000001,
    ST_SA   = 21'h000002,
    ST_SB   = 21'h000004,
    ST_SC   = 21'h000008,
    ST_TA   = 21'h000010,
    ST_TB   = 21'h000020,
    ST_TC   = 21'h000040,
    ST_WA   = 21'h000080,
    ST_WB   = 21'h000100,
    ST_WC   = 21'h000200,
    ST_WD   = 21'h000400,
    ST_PA   = 21'h000800,
    ST_PB   = 21'h001000,
    ST_PC   = 21'h002000,
    ST_PD   = 21'h004000,
    ST_RA   = 21'h008000,
    ST_RB   = 21'h010000,
    ST_KA   = 21'h020000,
    ST_KB   = 21'h040000,
    ST_KC   = 21'h080000,
    ST_KD   = 21'h100000
  } state_t;

  typedef struct packed {
    logic [1:0]       action;
    logic [ByteW-1:0] device_address;
    logic [ByteW-1:0] register_address;
    logic [ByteW-1:0] write_data;
    logic [ByteW-1:0] read_count;
    logic             sda_sample;
  } item_t;

  typedef struct packed {
    logic             scl_release;
    logic             sda_release;
    logic             busy_res;
    logic             byte_valid;
    logic [ByteW-1:0] read_byte;
    logic             last_byte;
    logic             done_res;
    logic [1:0]       error_code;
  } result_t;

endpackage

FILE: design/i2cm_in_reg.sv
// ----------------------------------------------------------------------------
// I2C master input register
// Holds one tick word until the sequencer consumes it.
// ----------------------------------------------------------------------------
module i2cm_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  i2cm_pkg::item_t in_item,
  input  logic           take,
  output logic           held_valid,
  output i2cm_pkg::item_t held_item
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

FILE: design/i2cm_engine.sv
// ----------------------------------------------------------------------------
// I2C master bus sequencer
// Advances the bus state by one tick per consumed word and forms its result.
// ----------------------------------------------------------------------------
module i2cm_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             step_en,
  input  i2cm_pkg::item_t  item,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_data,
  output i2cm_pkg::result_t res
);

  logic [7:0]             phase_ticks;
  i2cm_pkg::state_t       step, step_next;
  logic [7:0]             phase_timer, phase_timer_next;
  logic [3:0]             bit_counter, bit_counter_next;
  logic [7:0]             shift_byte, shift_byte_next;
  logic [7:0]             bytes_remaining, bytes_remaining_next;
  logic [23:0]            held_request, held_request_next;
  logic                   is_read, is_read_next;
  logic                   scl_level, scl_level_next;
  logic                   sda_level, sda_level_next;
  logic [1:0]             byte_stage, byte_stage_next;

  always_comb begin
    logic       fin;
    logic [1:0] fin_err;
    logic       sda_in;
    fin                  = 1'b0;
    fin_err              = i2cm_pkg::ERR_OK;
    sda_in               = item.sda_sample;
    step_next            = step;
    phase_timer_next     = phase_timer;
    bit_counter_next     = bit_counter;
    shift_byte_next      = shift_byte;
    bytes_remaining_next = bytes_remaining;
    held_request_next    = held_request;
    is_read_next         = is_read;
    scl_level_next       = scl_level;
    sda_level_next       = sda_level;
    byte_stage_next      = byte_stage;
    res                  = '0;

    if (step == i2cm_pkg::ST_IDLE) begin
      scl_level_next = 1'b1;
      sda_level_next = 1'b1;
      if (item.action == i2cm_pkg::ACT_WRITE || item.action == i2cm_pkg::ACT_READ) begin
        held_request_next    = {item.device_address, item.register_address, item.write_data};
        is_read_next         = (item.action == i2cm_pkg::ACT_READ);
        bytes_remaining_next = is_read_next ? item.read_count : 8'd0;
        if (is_read_next && item.read_count == 8'd0) begin
          fin     = 1'b1;
          fin_err = i2cm_pkg::ERR_ZERO_CNT;
        end else begin
          step_next        = i2cm_pkg::ST_SA;
          phase_timer_next = 8'd0;
          byte_stage_next  = 2'd0;
          bit_counter_next = 4'd0;
          shift_byte_next  = 8'd0;
        end
      end
    end

    if (step_next != i2cm_pkg::ST_IDLE && !fin) begin
      // pin levels for the current phase
      case (step_next)
        i2cm_pkg::ST_SA: begin
          scl_level_next = 1'b1; sda_level_next = 1'b1;
        end
        i2cm_pkg::ST_SB, i2cm_pkg::ST_SC: begin
          scl_level_next = 1'b1; sda_level_next = 1'b0;
        end
        i2cm_pkg::ST_TA, i2cm_pkg::ST_WA, i2cm_pkg::ST_PA, i2cm_pkg::ST_KA,
        i2cm_pkg::ST_KD: begin
          scl_level_next = 1'b0;
        end
        i2cm_pkg::ST_TB: begin
          scl_level_next = 1'b0;
          sda_level_next = |(shift_byte_next & i2cm_pkg::BIT_MSB);
        end
        i2cm_pkg::ST_TC, i2cm_pkg::ST_KC: begin
          scl_level_next = 1'b1;
        end
        i2cm_pkg::ST_WB, i2cm_pkg::ST_WD, i2cm_pkg::ST_RA: begin
          scl_level_next = 1'b0; sda_level_next = 1'b1;
        end
        i2cm_pkg::ST_WC, i2cm_pkg::ST_PD, i2cm_pkg::ST_RB: begin
          scl_level_next = 1'b1; sda_level_next = 1'b1;
        end
        i2cm_pkg::ST_PB: begin
          scl_level_next = 1'b0; sda_level_next = 1'b0;
        end
        i2cm_pkg::ST_PC: begin
          scl_level_next = 1'b1; sda_level_next = 1'b0;
        end
        i2cm_pkg::ST_KB: begin
          scl_level_next = 1'b0;
          sda_level_next = (bytes_remaining_next == 8'd1);
        end
        default: begin
          scl_level_next = 1'b1; sda_level_next = 1'b1;
        end
      endcase

      if (phase_timer_next < phase_ticks) begin
        phase_timer_next = phase_timer_next + 8'd1;
      end else begin
        phase_timer_next = 8'd0;
        case (step_next)
          i2cm_pkg::ST_SA: begin
            // bus must be free before the first start
            if (byte_stage_next == 2'd0 && !sda_in) begin
              fin = 1'b1; fin_err = i2cm_pkg::ERR_START;
            end else begin
              step_next = i2cm_pkg::ST_SB;
            end
          end
          i2cm_pkg::ST_SB: begin
            if (byte_stage_next == 2'd0 && sda_in) begin
              fin = 1'b1; fin_err = i2cm_pkg::ERR_START;
            end else begin
              step_next = i2cm_pkg::ST_SC;
            end
          end
          i2cm_pkg::ST_SC: begin
            shift_byte_next  = (byte_stage_next == 2'd0) ? held_request_next[23:16]
                                                         : held_request_next[23:16] + 8'd1;
            bit_counter_next = 4'd0;
            step_next        = i2cm_pkg::ST_TA;
          end
          i2cm_pkg::ST_TA: step_next = i2cm_pkg::ST_TB;
          i2cm_pkg::ST_TB: step_next = i2cm_pkg::ST_TC;
          i2cm_pkg::ST_TC: begin
            shift_byte_next  = {shift_byte_next[6:0], 1'b0};
            bit_counter_next = bit_counter_next + 4'd1;
            if (bit_counter_next >= 4'd8) begin
              bit_counter_next = 4'd0;
              step_next        = i2cm_pkg::ST_WA;
            end else begin
              step_next = i2cm_pkg::ST_TA;
            end
          end
          i2cm_pkg::ST_WA: step_next = i2cm_pkg::ST_WB;
          i2cm_pkg::ST_WB: step_next = i2cm_pkg::ST_WC;
          i2cm_pkg::ST_WC: begin
            // only the first address ack is checked
            if (!(byte_stage_next == 2'd0 && sda_in)) begin
              byte_stage_next = byte_stage_next + 2'd1;
            end
            step_next = i2cm_pkg::ST_WD;
          end
          i2cm_pkg::ST_WD: begin
            case (byte_stage_next)
              2'd0: step_next = i2cm_pkg::ST_PA;
              2'd1: begin
                shift_byte_next  = held_request_next[15:8];
                bit_counter_next = 4'd0;
                step_next        = i2cm_pkg::ST_TA;
              end
              2'd2: begin
                if (is_read_next) begin
                  step_next = i2cm_pkg::ST_SA;
                end else begin
                  shift_byte_next  = held_request_next[7:0];
                  bit_counter_next = 4'd0;
                  step_next        = i2cm_pkg::ST_TA;
                end
              end
              default: begin
                if (is_read_next) begin
                  shift_byte_next  = 8'd0;
                  bit_counter_next = 4'd0;
                  step_next        = i2cm_pkg::ST_RA;
                end else begin
                  step_next = i2cm_pkg::ST_PA;
                end
              end
            endcase
          end
          i2cm_pkg::ST_PA: step_next = i2cm_pkg::ST_PB;
          i2cm_pkg::ST_PB: step_next = i2cm_pkg::ST_PC;
          i2cm_pkg::ST_PC: step_next = i2cm_pkg::ST_PD;
          i2cm_pkg::ST_PD: begin
            fin     = 1'b1;
            fin_err = (byte_stage_next == 2'd0) ? i2cm_pkg::ERR_ADDR_NACK : i2cm_pkg::ERR_OK;
          end
          i2cm_pkg::ST_RA: step_next = i2cm_pkg::ST_RB;
          i2cm_pkg::ST_RB: begin
            shift_byte_next  = {shift_byte_next[6:0], sda_in};
            bit_counter_next = bit_counter_next + 4'd1;
            if (bit_counter_next >= 4'd8) begin
              bit_counter_next = 4'd0;
              res.byte_valid   = 1'b1;
              res.read_byte    = shift_byte_next;
              res.last_byte    = (bytes_remaining_next == 8'd1);
              step_next        = i2cm_pkg::ST_KA;
            end else begin
              step_next = i2cm_pkg::ST_RA;
            end
          end
          i2cm_pkg::ST_KA: step_next = i2cm_pkg::ST_KB;
          i2cm_pkg::ST_KB: step_next = i2cm_pkg::ST_KC;
          i2cm_pkg::ST_KC: step_next = i2cm_pkg::ST_KD;
          i2cm_pkg::ST_KD: begin
            bytes_remaining_next = bytes_remaining_next - 8'd1;
            if (bytes_remaining_next == 8'd0) begin
              step_next = i2cm_pkg::ST_PA;
            end else begin
              shift_byte_next = 8'd0;
              step_next       = i2cm_pkg::ST_RA;
            end
          end
          default: step_next = i2cm_pkg::ST_IDLE;
        endcase
      end
    end

    if (fin) begin
      step_next        = i2cm_pkg::ST_IDLE;
      phase_timer_next = 8'd0;
      scl_level_next   = 1'b1;
      sda_level_next   = 1'b1;
      res.done_res     = 1'b1;
      res.error_code   = fin_err;
    end

    res.scl_release = scl_level_next;
    res.sda_release = sda_level_next;
    res.busy_res    = (step_next != i2cm_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= 8'd0;
    end else if (cfg_we) begin
      phase_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step            <= i2cm_pkg::ST_IDLE;
      phase_timer     <= 8'd0;
      bit_counter     <= 4'd0;
      shift_byte      <= 8'd0;
      bytes_remaining <= 8'd0;
      is_read         <= 1'b0;
      scl_level       <= 1'b1;
      sda_level       <= 1'b1;
      byte_stage      <= 2'd0;
    end else if (step_en) begin
      step            <= step_next;
      phase_timer     <= phase_timer_next;
      bit_counter     <= bit_counter_next;
      shift_byte      <= shift_byte_next;
      bytes_remaining <= bytes_remaining_next;
      is_read         <= is_read_next;
      scl_level       <= scl_level_next;
      sda_level       <= sda_level_next;
      byte_stage      <= byte_stage_next;
    end
  end

  // request fields need no reset, always written before use
  always_ff @(posedge clk) begin
    if (step_en) begin
      held_request <= held_request_next;
    end
  end

endmodule

FILE: design/i2cm_out_reg.sv
// ----------------------------------------------------------------------------
// I2C master result register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module i2cm_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  i2cm_pkg::result_t load_res,
  output logic             out_free,
  output logic             out_valid,
  input  logic             out_ready,
  output i2cm_pkg::result_t out_res
);

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && out_free) begin
      out_res <= load_res;
    end
  end

endmodule

FILE: design/i2c_master_register_access_core.sv
// ----------------------------------------------------------------------------
// I2C master register access core
// Tick-driven open-drain I2C master for register writes and burst reads.
// ----------------------------------------------------------------------------
// Each input word is one bus tick: the sampled SDA level plus an optional
// request (write or burst read). Each input word yields exactly one result
// word with the SCL/SDA release levels, busy, a received byte strobe and a
// done strobe with its error code. Requests while busy are ignored.
// The cfg channel writes phase_ticks (always ready); write it only while
// the core is idle. Each pin phase lasts phase_ticks+1 ticks.
// Registers: an accepted word passes the input register, then the
// sequencer logic and the result register (two registers: input, result).
// Throughput: one word per cycle while out_ready is high; the sequencer
// logic between the input and result registers is the only stage.
// Stalls: when out_ready is low the result is held and the input register
// fills; in_ready drops only when both are occupied.
// Reset: bus lines released, sequencer idle, phase_ticks zero, both
// registers empty.
// ----------------------------------------------------------------------------
module i2c_master_register_access_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  input  logic [7:0] device_address,
  input  logic [7:0] register_address,
  input  logic [7:0] write_data,
  input  logic [7:0] read_count,
  input  logic       sda_sample,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       scl_release,
  output logic       sda_release,
  output logic       busy_res,
  output logic       byte_valid,
  output logic [7:0] read_byte,
  output logic       last_byte,
  output logic       done_res,
  output logic [1:0] error_code,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  i2cm_pkg::item_t   in_item, held_item;
  i2cm_pkg::result_t step_res, out_res;
  logic              held_valid, out_free, take;

  assign in_item   = '{action, device_address, register_address, write_data,
                       read_count, sda_sample};
  assign take      = held_valid && out_free;
  assign cfg_ready = 1'b1;

  i2cm_in_reg u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .take      (take),
    .held_valid(held_valid),
    .held_item (held_item)
  );

  i2cm_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .step_en (take),
    .item    (held_item),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_data(cfg_data),
    .res     (step_res)
  );

  i2cm_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (take),
    .load_res (step_res),
    .out_free (out_free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (out_res)
  );

  assign scl_release = out_res.scl_release;
  assign sda_release = out_res.sda_release;
  assign busy_res    = out_res.busy_res;
  assign byte_valid  = out_res.byte_valid;
  assign read_byte   = out_res.read_byte;
  assign last_byte   = out_res.last_byte;
  assign done_res    = out_res.done_res;
  assign error_code  = out_res.error_code;

endmodule

FILE: design/i2cm_checker.sv
// ----------------------------------------------------------------------------
// I2C master port checker
// Port-level properties of the register access core, bound to the top.
// ----------------------------------------------------------------------------
module i2cm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       scl_release,
  input logic       sda_release,
  input logic       busy_res,
  input logic       byte_valid,
  input logic [7:0] read_byte,
  input logic       last_byte,
  input logic       done_res,
  input logic [1:0] error_code
);

  // a finished transaction leaves the core idle
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done reported while busy");

  a_err_with_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != i2cm_pkg::ERR_OK |-> done_res)
    else $error("error code without done");

  a_byte_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> read_byte == 8'd0 && !last_byte)
    else $error("byte fields set without byte strobe");

  // a stalled result word stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(scl_release) &&
      $stable(sda_release) && $stable(busy_res) && $stable(byte_valid) &&
      $stable(read_byte) && $stable(last_byte) && $stable(done_res) &&
      $stable(error_code))
    else $error("result word changed while stalled");

  // with a free result register the input side never stalls
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind i2c_master_register_access_core i2cm_checker u_i2cm_checker (.*);

FILE: test/tb_i2c_master_register_access_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master register access core testbench
// Drives bus ticks with register writes, burst reads and a responder that
// plays the slave side on sda_sample. A cycle-exact bus model predicts every
// result word, which is checked field by field as it leaves the core.
// ----------------------------------------------------------------------------
module tb_i2c_master_register_access_core;

  localparam logic [1:0] ACT_NONE = 2'd3;  // decodes as tick only
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int TICKS_PER_PASS = 40;
  localparam int DRAIN_CYCLES = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic            in_valid = 1'b0;
  logic            in_ready;
  i2cm_pkg::item_t in_word = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic  scl_release, sda_release, busy_res, byte_valid, last_byte, done_res;
  logic [7:0] read_byte;
  logic [1:0] error_code;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;

  i2c_master_register_access_core i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .action           (in_word.action),
    .device_address   (in_word.device_address),
    .register_address (in_word.register_address),
    .write_data       (in_word.write_data),
    .read_count       (in_word.read_count),
    .sda_sample       (in_word.sda_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .scl_release      (scl_release),
    .sda_release      (sda_release),
    .busy_res         (busy_res),
    .byte_valid       (byte_valid),
    .read_byte        (read_byte),
    .last_byte        (last_byte),
    .done_res         (done_res),
    .error_code       (error_code),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // bus model state
  i2cm_pkg::state_t bm_step  = i2cm_pkg::ST_IDLE;
  logic [7:0]  bm_timer = '0;
  logic [3:0]  bm_bits  = '0;
  logic [7:0]  bm_shift = '0;
  logic [7:0]  bm_left  = '0;
  logic [23:0] bm_req   = '0;
  logic        bm_read  = 1'b0;
  logic        bm_scl   = 1'b1;
  logic        bm_sda   = 1'b1;
  logic [1:0]  bm_stage = '0;   // acked slots: address, register, then write data or read address
  logic [7:0]  bm_phase = '0;

  // slave responder knobs
  logic noise     = 1'b0;
  logic sa_level  = 1'b1;  // bus free before start
  logic sb_level  = 1'b0;  // line follows the start
  logic ack_level = 1'b0;  // address ack

  i2cm_pkg::result_t expected_ticks[$];
  i2cm_pkg::result_t exp_r;
  int          mismatches  = 0;
  int unsigned cycle_count = 0;
  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  int          hold_ask  = 0;
  int          hold_left = 0;

  task automatic bus_finish(input logic [1:0] err, inout i2cm_pkg::result_t r);
    r.done_res   = 1'b1;
    r.error_code = err;
    bm_step  = i2cm_pkg::ST_IDLE;
    bm_timer = '0;
    bm_scl   = 1'b1;
    bm_sda   = 1'b1;
  endtask

  task automatic bus_load(input logic [7:0] value);
    bm_shift = value;
    bm_bits  = '0;
    bm_step  = i2cm_pkg::ST_TA;
  endtask

  task automatic bus_step(input i2cm_pkg::item_t it, output i2cm_pkg::result_t r);
    r = '0;
    if (bm_step == i2cm_pkg::ST_IDLE) begin
      bm_scl = 1'b1;
      bm_sda = 1'b1;
      if (it.action == i2cm_pkg::ACT_WRITE || it.action == i2cm_pkg::ACT_READ) begin
        bm_req  = {it.device_address, it.register_address, it.write_data};
        bm_read = (it.action == i2cm_pkg::ACT_READ);
        bm_left = bm_read ? it.read_count : 8'd0;
        if (bm_read && it.read_count == 8'd0) begin
          bus_finish(i2cm_pkg::ERR_ZERO_CNT, r);
        end else begin
          bm_step  = i2cm_pkg::ST_SA;
          bm_timer = '0;
          bm_stage = '0;
          bm_bits  = '0;
          bm_shift = '0;
        end
      end
    end

    if (bm_step != i2cm_pkg::ST_IDLE) begin
      case (bm_step)
        i2cm_pkg::ST_SA: begin bm_scl = 1'b1; bm_sda = 1'b1; end
        i2cm_pkg::ST_SB, i2cm_pkg::ST_SC: begin bm_scl = 1'b1; bm_sda = 1'b0; end
        i2cm_pkg::ST_TA, i2cm_pkg::ST_WA, i2cm_pkg::ST_PA, i2cm_pkg::ST_KA,
        i2cm_pkg::ST_KD: bm_scl = 1'b0;
        i2cm_pkg::ST_TB: begin bm_scl = 1'b0; bm_sda = bm_shift[7]; end
        i2cm_pkg::ST_TC, i2cm_pkg::ST_KC: bm_scl = 1'b1;
        i2cm_pkg::ST_WB, i2cm_pkg::ST_WD, i2cm_pkg::ST_RA: begin
          bm_scl = 1'b0; bm_sda = 1'b1;
        end
        i2cm_pkg::ST_PB: begin bm_scl = 1'b0; bm_sda = 1'b0; end
        i2cm_pkg::ST_PC: begin bm_scl = 1'b1; bm_sda = 1'b0; end
        i2cm_pkg::ST_KB: begin bm_scl = 1'b0; bm_sda = (bm_left == 8'd1); end
        default: begin bm_scl = 1'b1; bm_sda = 1'b1; end
      endcase

      if (bm_timer < bm_phase) begin
        bm_timer = bm_timer + 8'd1;
      end else begin
        bm_timer = '0;
        case (bm_step)
          i2cm_pkg::ST_SA: begin
            if (bm_stage == 2'd0 && !it.sda_sample) bus_finish(i2cm_pkg::ERR_START, r);
            else bm_step = i2cm_pkg::ST_SB;
          end
          i2cm_pkg::ST_SB: begin
            if (bm_stage == 2'd0 && it.sda_sample) bus_finish(i2cm_pkg::ERR_START, r);
            else bm_step = i2cm_pkg::ST_SC;
          end
          // repeated start sends the read address
          i2cm_pkg::ST_SC:
            bus_load((bm_stage == 2'd0) ? bm_req[23:16] : bm_req[23:16] + 8'd1);
          i2cm_pkg::ST_TA: bm_step = i2cm_pkg::ST_TB;
          i2cm_pkg::ST_TB: bm_step = i2cm_pkg::ST_TC;
          i2cm_pkg::ST_TC: begin
            bm_shift = {bm_shift[6:0], 1'b0};
            bm_bits  = bm_bits + 4'd1;
            if (bm_bits >= 4'd8) begin
              bm_bits = '0;
              bm_step = i2cm_pkg::ST_WA;
            end else begin
              bm_step = i2cm_pkg::ST_TA;
            end
          end
          i2cm_pkg::ST_WA: bm_step = i2cm_pkg::ST_WB;
          i2cm_pkg::ST_WB: bm_step = i2cm_pkg::ST_WC;
          i2cm_pkg::ST_WC: begin
            // only the first address ack is checked
            if (!(bm_stage == 2'd0 && it.sda_sample)) bm_stage = bm_stage + 2'd1;
            bm_step = i2cm_pkg::ST_WD;
          end
          i2cm_pkg::ST_WD: begin
            case (bm_stage)
              2'd0: bm_step = i2cm_pkg::ST_PA;
              2'd1: bus_load(bm_req[15:8]);
              2'd2: begin
                if (bm_read) bm_step = i2cm_pkg::ST_SA;
                else bus_load(bm_req[7:0]);
              end
              default: begin
                if (bm_read) begin
                  bm_shift = '0;
                  bm_bits  = '0;
                  bm_step  = i2cm_pkg::ST_RA;
                end else begin
                  bm_step = i2cm_pkg::ST_PA;
                end
              end
            endcase
          end
          i2cm_pkg::ST_PA: bm_step = i2cm_pkg::ST_PB;
          i2cm_pkg::ST_PB: bm_step = i2cm_pkg::ST_PC;
          i2cm_pkg::ST_PC: bm_step = i2cm_pkg::ST_PD;
          i2cm_pkg::ST_PD:
            bus_finish((bm_stage == 2'd0) ? i2cm_pkg::ERR_ADDR_NACK : i2cm_pkg::ERR_OK, r);
          i2cm_pkg::ST_RA: bm_step = i2cm_pkg::ST_RB;
          i2cm_pkg::ST_RB: begin
            bm_shift = {bm_shift[6:0], it.sda_sample};
            bm_bits  = bm_bits + 4'd1;
            if (bm_bits >= 4'd8) begin
              bm_bits     = '0;
              r.byte_valid = 1'b1;
              r.read_byte  = bm_shift;
              r.last_byte  = (bm_left == 8'd1);
              bm_step     = i2cm_pkg::ST_KA;
            end else begin
              bm_step = i2cm_pkg::ST_RA;
            end
          end
          i2cm_pkg::ST_KA: bm_step = i2cm_pkg::ST_KB;
          i2cm_pkg::ST_KB: bm_step = i2cm_pkg::ST_KC;
          i2cm_pkg::ST_KC: bm_step = i2cm_pkg::ST_KD;
          i2cm_pkg::ST_KD: begin
            bm_left = bm_left - 8'd1;
            if (bm_left == 8'd0) begin
              bm_step = i2cm_pkg::ST_PA;
            end else begin
              bm_shift = '0;
              bm_step  = i2cm_pkg::ST_RA;
            end
          end
          default: bm_step = i2cm_pkg::ST_IDLE;
        endcase
      end
    end

    r.scl_release = bm_scl;
    r.sda_release = bm_sda;
    r.busy_res    = (bm_step != i2cm_pkg::ST_IDLE);
  endtask

  // slave side: answers the sample the model is about to take
  function automatic logic bus_sda();
    if (noise) return 1'($urandom_range(0, 1));
    case (bm_step)
      i2cm_pkg::ST_IDLE: return sa_level;  // request tick is the first start tick
      i2cm_pkg::ST_SA: return (bm_stage == 2'd0) ? sa_level : 1'b1;
      i2cm_pkg::ST_SB, i2cm_pkg::ST_SC: return (bm_stage == 2'd0) ? sb_level : 1'b0;
      i2cm_pkg::ST_WA, i2cm_pkg::ST_WB, i2cm_pkg::ST_WC:
        return (bm_stage == 2'd0) ? ack_level : 1'($urandom_range(0, 1));
      default: return 1'($urandom_range(0, 1));
    endcase
  endfunction

  function automatic i2cm_pkg::item_t random_item();
    i2cm_pkg::item_t it;
    it.action           = 2'($urandom_range(0, 3));
    it.device_address   = 8'($urandom);
    it.register_address = 8'($urandom);
    it.write_data       = 8'($urandom);
    it.read_count       = 8'($urandom);
    it.sda_sample       = 1'b0;
    return it;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_tick(input i2cm_pkg::item_t it);
    i2cm_pkg::result_t r;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    it.sda_sample = bus_sda();
    in_word  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    bus_step(it, r);
    expected_ticks.push_back(r);
    @(negedge clk);
  endtask

  task automatic run_txn(input logic [1:0] act, input logic [7:0] dev, input logic [7:0] rega,
                         input logic [7:0] dat, input logic [7:0] cnt);
    i2cm_pkg::item_t it;
    it = random_item();
    it.action           = act;
    it.device_address   = dev;
    it.register_address = rega;
    it.write_data       = dat;
    it.read_count       = cnt;
    send_tick(it);
    // random requests during the transaction must be ignored
    while (bm_step != i2cm_pkg::ST_IDLE) send_tick(random_item());
  endtask

  task automatic write_phase(input logic [7:0] value);
    in_valid <= 1'b0;
    while (expected_ticks.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    bm_phase = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic bus_defaults();
    noise     = 1'b0;
    sa_level  = 1'b1;
    sb_level  = 1'b0;
    ack_level = 1'b0;
  endtask

  task automatic test_write();
    run_txn(i2cm_pkg::ACT_WRITE, 8'hFF, 8'h00, 8'hA5, 8'hFF);
  endtask

  task automatic test_reads();
    // read address wraps to 0, first byte acked, last byte nacked
    run_txn(i2cm_pkg::ACT_READ, 8'hFF, 8'h80, 8'h00, 8'd2);
  endtask

  task automatic test_zero_count();
    run_txn(i2cm_pkg::ACT_READ, 8'h52, 8'h11, 8'h00, 8'd0);
  endtask

  task automatic test_start_fail();
    sa_level = 1'b0;
    run_txn(i2cm_pkg::ACT_WRITE, 8'h20, 8'h01, 8'h02, 8'd0);
    bus_defaults();
    sb_level = 1'b1;
    run_txn(i2cm_pkg::ACT_READ, 8'h20, 8'h01, 8'h02, 8'd2);
    bus_defaults();
  endtask

  task automatic test_addr_nack();
    ack_level = 1'b1;
    run_txn(i2cm_pkg::ACT_READ, 8'h90, 8'h10, 8'h55, 8'd4);
    bus_defaults();
  endtask

  task automatic test_tick_only();
    run_txn(i2cm_pkg::ACT_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    run_txn(ACT_NONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
  endtask

  // longest phase: the start check fails after a full 256-tick phase
  task automatic test_phase_extremes();
    write_phase(8'd255);
    sa_level = 1'b0;
    run_txn(i2cm_pkg::ACT_WRITE, 8'h6A, 8'hC3, 8'h96, 8'd0);
    bus_defaults();
    write_phase(8'd0);
  endtask

  // receiver stops for a long stretch while the sender keeps offering words
  task automatic test_backpressure();
    i2cm_pkg::item_t it;
    hold_ask = 300;
    repeat (20) begin
      it = random_item();
      it.action = i2cm_pkg::ACT_TICK;
      send_tick(it);
    end
  endtask

  task automatic test_random(input int snd_pct, input int rcv_pct);
    int              pick;
    i2cm_pkg::item_t it;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    for (int n = 0; n < TICKS_PER_PASS; n++) begin
      it = random_item();
      if (bm_step == i2cm_pkg::ST_IDLE) begin
        if ($urandom_range(0, 7) == 0) write_phase(8'($urandom_range(0, 2)));
        noise     = ($urandom_range(0, 9) == 0);
        sa_level  = ($urandom_range(0, 99) >= 3);
        sb_level  = ($urandom_range(0, 99) < 3);
        ack_level = ($urandom_range(0, 99) < 8);
        pick = $urandom_range(0, 11);
        if (pick == 0) it.read_count = 8'd0;
        else if (pick < 3) it.read_count = 8'($urandom_range(5, 12));
        else it.read_count = 8'($urandom_range(1, 4));
        pick = $urandom_range(0, 19);
        if (pick == 0) it.action = ACT_NONE;
        else if (pick < 4) it.action = i2cm_pkg::ACT_TICK;
        else if (pick < 12) it.action = i2cm_pkg::ACT_WRITE;
        else it.action = i2cm_pkg::ACT_READ;
      end
      send_tick(it);
    end
    bus_defaults();
  endtask

  // receiver
  always @(negedge clk) begin
    if (hold_ask != 0) begin
      hold_left = hold_ask;
      hold_ask  = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_ticks.size() == 0) begin
        $error("result word with nothing expected");
        mismatches++;
      end else begin
        exp_r = expected_ticks.pop_front();
        check_field("scl_release", exp_r.scl_release, scl_release);
        check_field("sda_release", exp_r.sda_release, sda_release);
        check_field("busy_res", exp_r.busy_res, busy_res);
        check_field("byte_valid", exp_r.byte_valid, byte_valid);
        check_field("read_byte", exp_r.read_byte, read_byte);
        check_field("last_byte", exp_r.last_byte, last_byte);
        check_field("done_res", exp_r.done_res, done_res);
        check_field("error_code", exp_r.error_code, error_code);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_phase(8'd0);
    test_write();
    test_reads();
    test_zero_count();
    test_start_fail();
    test_addr_nack();
    test_tick_only();
    test_phase_extremes();
    test_backpressure();

    test_random(9, 81);
    test_random(81, 9);
    test_random(0, 0);

    in_valid <= 1'b0;
    while (expected_ticks.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
